### design/led_effect_generator_top_assert.svh
// ----------------------------------------------------------------------------
// led effect generator assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LED_EFFECT_GENERATOR_TOP_ASSERT_SVH
`define LED_EFFECT_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define LFX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ledfx_pkg.sv
// ----------------------------------------------------------------------------
// ledfx_pkg
// shared constants, types and the breathing sine table of the led effect block
// ----------------------------------------------------------------------------
`default_nettype none

package ledfx_pkg;

  // command codes
  localparam int          CMD_W     = 2;
  localparam logic [1:0]  CMD_TICK  = 2'd0;
  localparam logic [1:0]  CMD_START = 2'd1;
  localparam logic [1:0]  CMD_STOP  = 2'd2;

  // effect modes
  localparam int          MODE_W      = 2;
  localparam logic [1:0]  MODE_NONE   = 2'd0;
  localparam logic [1:0]  MODE_BLINK  = 2'd1;
  localparam logic [1:0]  MODE_BREATH = 2'd2;
  localparam logic [1:0]  MODE_WHEEL  = 2'd3;

  // register indexes
  localparam int          CFG_IDX_W  = 3;
  localparam logic [2:0]  REG_MODE   = 3'd0;
  localparam logic [2:0]  REG_COLOR  = 3'd1;
  localparam logic [2:0]  REG_PERIOD = 3'd2;
  localparam logic [2:0]  REG_LIMIT  = 3'd3;
  localparam logic [2:0]  REG_BRIGHT = 3'd4;

  // field widths
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int BRIGHT_W   = 8;
  localparam int TIME_W     = 32;
  localparam int PHASE_W    = 24;
  localparam int STEP_W     = PHASE_W + 1;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd255;
  localparam logic [STEP_W-1:0]   ONE_TURN     = {1'b1, {PHASE_W{1'b0}}};

  // effect timing
  localparam int TICK_MS      = 10;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int SINE_V_W     = 32;

  // shared divider
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);
  localparam logic [DIV_N_W-1:0] STEP_NUM = DIV_N_W'(TICK_MS) << PHASE_W;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_EFF,
    ST_STEP_CHK,
    ST_DIV_STEP,
    ST_LUT,
    ST_MUL,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic halt;
    logic eff_from_period;
    logic div_go;
    logic div_sel;
    logic latch_eff;
    logic latch_step;
    logic set_active;
    logic set_black;
    logic tick;
    logic lut;
    logic mul;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             active;
    logic             limit_nz;
    logic             eff_zero;
    logic             div_done;
    logic             tick_emit;
    logic             tick_level;
  } dp_stat_t;

  // (1 +/- sin) in q30, one entry per table sample
  typedef logic [SINE_V_W-1:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] a3;
    logic [63:0] a5;
    logic [63:0] a7;
    logic [63:0] a9;
    logic [63:0] s;
    logic [63:0] v;
    logic        neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      u   = (64'(k) << 32) / SINE_ENTRIES;
      neg = 1'b0;
      if (u >= 64'h8000_0000) begin
        neg = 1'b1;
        u   = u - 64'h8000_0000;
      end
      if (u > 64'h4000_0000) u = 64'h8000_0000 - u;
      t  = (u * 64'd6746518852) >> 32;
      t2 = (t * t) >> 30;
      a3 = ((t * t2) >> 30) / 6;
      a5 = ((a3 * t2) >> 30) / 20;
      a7 = ((a5 * t2) >> 30) / 42;
      a9 = ((a7 * t2) >> 30) / 72;
      s  = (t - a3) + a5 - a7 + a9;
      if (s > 64'h4000_0000) s = 64'h4000_0000;
      v  = neg ? (64'h4000_0000 - s) : (64'h4000_0000 + s);
      rom[k] = v[SINE_V_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### design/ledfx_div.sv
// ----------------------------------------------------------------------------
// ledfx_div
// restoring divider, one quotient bit per cycle, done pulses after the last
// ----------------------------------------------------------------------------
`default_nettype none

module ledfx_div
  import ledfx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     rem_diff;
  logic                 fits;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_N_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    fits     = rem_sh >= {1'b0, dvs_r};
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### design/ledfx_dpath.sv
// ----------------------------------------------------------------------------
// ledfx_dpath
// effect state, configuration registers, tick update, breathing level and
// the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ledfx_dpath
  import ledfx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire ctrl_cmd_t             ctl,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam logic [CHAN_W-1:0] WHEEL_SEG1 = 8'd85;
  localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam int SIDX_PROD_W = PHASE_W + $clog2(SINE_ENTRIES + 1);
  localparam int LVL_PROD_W  = BRIGHT_W + SINE_V_W;
  localparam int OUT_PAD_W   = OUT_DATA_W - COLOR_W - BRIGHT_W - 1;

  // three-segment color wheel
  function automatic logic [COLOR_W-1:0] wheel_color(input logic [CHAN_W-1:0] pos);
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] up;
    logic [CHAN_W-1:0] dn;
    logic [COLOR_W-1:0] c;
    p = CHAN_MAX - pos;
    if (p < WHEEL_SEG1) begin
      up = CHAN_W'(10'(p) * 10'd3);
      dn = CHAN_MAX - up;
      c  = {dn, 8'd0, up};
    end else if (p < WHEEL_SEG2) begin
      up = CHAN_W'(10'(p - WHEEL_SEG1) * 10'd3);
      dn = CHAN_MAX - up;
      c  = {8'd0, up, dn};
    end else begin
      up = CHAN_W'(10'(p - WHEEL_SEG2) * 10'd3);
      dn = CHAN_MAX - up;
      c  = {up, dn, 8'd0};
    end
    return c;
  endfunction

  // configuration
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [COUNT_W-1:0]  limit_r, limit_nxt;
  logic [BRIGHT_W-1:0] bright_r, bright_nxt;

  // effect state
  logic                active_r, active_nxt;
  logic                lit_r, lit_nxt;
  logic [TIME_W-1:0]   last_upd_r, last_upd_nxt;
  logic [COUNT_W-1:0]  cyc_cnt_r, cyc_cnt_nxt;
  logic [PHASE_W-1:0]  breath_ph_r, breath_ph_nxt;
  logic [PHASE_W-1:0]  wheel_ph_r, wheel_ph_nxt;
  logic [PERIOD_W-1:0] eff_r, eff_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [BRIGHT_W-1:0] level_r, level_nxt;

  // item and result payload
  logic [CMD_W-1:0]      item_cmd_r;
  logic [TIME_W-1:0]     item_now_r;
  logic [COLOR_W-1:0]    res_color_r;
  logic [SINE_V_W-1:0]   sine_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // divider hookup
  logic                 div_done;
  logic [DIV_N_W-1:0]   div_quo;
  logic [DIV_N_W-1:0]   div_dvd;
  logic [DIV_D_W-1:0]   div_dvs;
  logic [STEP_W-1:0]    step_sat;

  // tick evaluation
  logic [TIME_W-1:0]    elapsed;
  logic                 blink_due;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 limit_hit;
  logic [STEP_W-1:0]    b_sum;
  logic [STEP_W-1:0]    w_sum;
  logic                 tick_emit;
  logic                 tick_level;
  logic [COLOR_W-1:0]   tick_color;

  // breathing level
  logic [SIDX_PROD_W-1:0] sidx_prod;
  logic [SINE_IDX_W-1:0]  sine_idx;
  logic [LVL_PROD_W-1:0]  lvl_prod;

  assign div_dvd = ctl.div_sel ? STEP_NUM : DIV_N_W'(period_r);
  assign div_dvs = ctl.div_sel ? eff_r : limit_r;

  ledfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctl.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // phase step saturates at one turn
  assign step_sat = (div_quo > DIV_N_W'(ONE_TURN)) ? ONE_TURN : div_quo[STEP_W-1:0];

  // sine table index and level product
  assign sidx_prod = SIDX_PROD_W'(breath_ph_r) * SIDX_PROD_W'(SINE_ENTRIES);
  assign sine_idx  = sidx_prod[PHASE_W +: SINE_IDX_W];
  assign lvl_prod  = LVL_PROD_W'(bright_r) * LVL_PROD_W'(sine_v_r);

  // what a tick would do in the current mode
  always_comb begin
    elapsed    = item_now_r - last_upd_r;
    blink_due  = elapsed >= TIME_W'(eff_r >> 1);
    cnt_inc    = cyc_cnt_r + 1'b1;
    limit_hit  = (limit_r != '0) && (cnt_inc >= limit_r);
    b_sum      = {1'b0, breath_ph_r} + step_r;
    w_sum      = {1'b0, wheel_ph_r} + step_r;
    tick_emit  = 1'b0;
    tick_level = 1'b0;
    tick_color = '0;
    unique case (mode_r)
      MODE_BLINK: begin
        tick_emit = blink_due;
        if (!lit_r && !limit_hit) tick_color = color_r;
      end
      MODE_BREATH: begin
        tick_emit = 1'b1;
        if (!(b_sum[PHASE_W] && limit_hit)) begin
          tick_level = 1'b1;
          tick_color = color_r;
        end
      end
      MODE_WHEEL: begin
        tick_emit = 1'b1;
        if (!(w_sum[PHASE_W] && limit_hit)) tick_color = wheel_color(w_sum[PHASE_W-1 -: CHAN_W]);
      end
      default: ;
    endcase
  end

  // state update
  always_comb begin
    mode_nxt      = mode_r;
    color_nxt     = color_r;
    period_nxt    = period_r;
    limit_nxt     = limit_r;
    bright_nxt    = bright_r;
    active_nxt    = active_r;
    lit_nxt       = lit_r;
    last_upd_nxt  = last_upd_r;
    cyc_cnt_nxt   = cyc_cnt_r;
    breath_ph_nxt = breath_ph_r;
    wheel_ph_nxt  = wheel_ph_r;
    eff_nxt       = eff_r;
    step_nxt      = step_r;
    level_nxt     = level_r;

    if (ctl.halt) begin
      active_nxt = 1'b0;
      lit_nxt    = 1'b0;
    end
    if (ctl.eff_from_period) eff_nxt = period_r;
    if (ctl.latch_eff) eff_nxt = div_quo[PERIOD_W-1:0];
    if (ctl.latch_step) step_nxt = (eff_r == '0) ? ONE_TURN : step_sat;
    if (ctl.set_active) active_nxt = 1'b1;
    if (ctl.mul) level_nxt = lvl_prod[SINE_V_W-1 +: BRIGHT_W];

    // tick
    if (ctl.tick) begin
      unique case (mode_r)
        MODE_BLINK: begin
          if (blink_due) begin
            last_upd_nxt = item_now_r;
            if (lit_r) begin
              lit_nxt = 1'b0;
            end else begin
              lit_nxt     = color_r != '0;
              cyc_cnt_nxt = cnt_inc;
              if (limit_hit) begin
                active_nxt = 1'b0;
                lit_nxt    = 1'b0;
              end
            end
          end
        end
        MODE_BREATH: begin
          last_upd_nxt  = item_now_r;
          breath_ph_nxt = b_sum[PHASE_W-1:0];
          lit_nxt       = color_r != '0;
          if (b_sum[PHASE_W]) begin
            cyc_cnt_nxt = cnt_inc;
            if (limit_hit) begin
              active_nxt = 1'b0;
              lit_nxt    = 1'b0;
            end
          end
        end
        MODE_WHEEL: begin
          last_upd_nxt = item_now_r;
          wheel_ph_nxt = w_sum[PHASE_W-1:0];
          lit_nxt      = 1'b1;
          if (w_sum[PHASE_W]) begin
            cyc_cnt_nxt = cnt_inc;
            if (limit_hit) begin
              active_nxt = 1'b0;
              lit_nxt    = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end

    // register writes clear the cycle count
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE: begin
          mode_nxt    = cfg_wdata[MODE_W-1:0];
          cyc_cnt_nxt = '0;
        end
        REG_COLOR: begin
          color_nxt   = cfg_wdata[COLOR_W-1:0];
          cyc_cnt_nxt = '0;
        end
        REG_PERIOD: begin
          period_nxt  = cfg_wdata[PERIOD_W-1:0];
          cyc_cnt_nxt = '0;
        end
        REG_LIMIT: begin
          limit_nxt   = cfg_wdata[COUNT_W-1:0];
          cyc_cnt_nxt = '0;
        end
        REG_BRIGHT: begin
          bright_nxt  = cfg_wdata[BRIGHT_W-1:0];
          cyc_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // configuration and effect state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NONE;
      color_r     <= '0;
      period_r    <= '0;
      limit_r     <= '0;
      bright_r    <= BRIGHT_RESET;
      active_r    <= 1'b0;
      lit_r       <= 1'b0;
      last_upd_r  <= '0;
      cyc_cnt_r   <= '0;
      breath_ph_r <= '0;
      wheel_ph_r  <= '0;
      eff_r       <= '0;
      step_r      <= '0;
      level_r     <= BRIGHT_RESET;
    end else begin
      mode_r      <= mode_nxt;
      color_r     <= color_nxt;
      period_r    <= period_nxt;
      limit_r     <= limit_nxt;
      bright_r    <= bright_nxt;
      active_r    <= active_nxt;
      lit_r       <= lit_nxt;
      last_upd_r  <= last_upd_nxt;
      cyc_cnt_r   <= cyc_cnt_nxt;
      breath_ph_r <= breath_ph_nxt;
      wheel_ph_r  <= wheel_ph_nxt;
      eff_r       <= eff_nxt;
      step_r      <= step_nxt;
      level_r     <= level_nxt;
    end
  end

  // item capture, result color, table read and result register
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd_r <= in_tdata[CMD_W-1:0];
      item_now_r <= in_tdata[CMD_W +: TIME_W];
    end
    if (ctl.set_black) res_color_r <= '0;
    else if (ctl.tick) res_color_r <= tick_color;
    if (ctl.lut) sine_v_r <= SINE_ROM[sine_idx];
    if (ctl.out_load) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, active_r, level_r,
                     res_color_r[7:0], res_color_r[15:8], res_color_r[23:16]};
    end
  end

  // status to the controller
  always_comb begin
    stat.cmd        = item_cmd_r;
    stat.active     = active_r;
    stat.limit_nz   = limit_r != '0;
    stat.eff_zero   = eff_r == '0;
    stat.div_done   = div_done;
    stat.tick_emit  = tick_emit;
    stat.tick_level = tick_level;
  end

  assign out_tdata = out_data_r;

endmodule

`default_nettype wire

### design/ledfx_ctrl.sv
// ----------------------------------------------------------------------------
// ledfx_ctrl
// sequencer for one item at a time: decode, divider runs, breathing level
// and the result handoff
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_effect_generator_top_assert.svh"

module ledfx_ctrl
  import ledfx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_START: state_nxt = stat.limit_nz ? ST_DIV_EFF : ST_STEP_CHK;
          CMD_STOP:  state_nxt = ST_EMIT;
          CMD_TICK: begin
            if (!stat.active) state_nxt = ST_IDLE;
            else if (stat.tick_level) state_nxt = ST_LUT;
            else if (stat.tick_emit) state_nxt = ST_EMIT;
            else state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DIV_EFF: begin
        if (stat.div_done) state_nxt = ST_STEP_CHK;
      end
      ST_STEP_CHK: begin
        state_nxt = stat.eff_zero ? ST_EMIT : ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (stat.div_done) state_nxt = ST_EMIT;
      end
      ST_LUT: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        ctl.capture = in_tvalid;
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_START: begin
            ctl.halt            = 1'b1;
            ctl.set_black       = 1'b1;
            ctl.div_go          = stat.limit_nz;
            ctl.eff_from_period = !stat.limit_nz;
          end
          CMD_STOP: begin
            ctl.halt      = 1'b1;
            ctl.set_black = 1'b1;
          end
          CMD_TICK: ctl.tick = stat.active;
          default: ;
        endcase
      end
      ST_DIV_EFF: ctl.latch_eff = stat.div_done;
      ST_STEP_CHK: begin
        ctl.latch_step = stat.eff_zero;
        ctl.set_active = stat.eff_zero;
        ctl.div_go     = !stat.eff_zero;
        ctl.div_sel    = 1'b1;
      end
      ST_DIV_STEP: begin
        ctl.div_sel    = 1'b1;
        ctl.latch_step = stat.div_done;
        ctl.set_active = stat.div_done;
      end
      ST_LUT: ctl.lut = 1'b1;
      ST_MUL: ctl.mul = 1'b1;
      ST_EMIT: ctl.out_load = out_free;
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // checks
  `LFX_ASSERT_IMP(a_load_free, ctl.out_load, (!out_valid_r || out_tready), "result overwrote a pending transfer")
  `LFX_ASSERT_NXT(a_load_shows, ctl.out_load, out_valid_r, "loaded result not presented")
  `LFX_ASSERT_IMP(a_div_nonzero, state_r == ST_DIV_STEP, !stat.eff_zero, "step division by zero period")
  `LFX_ASSERT_IMP(a_lut_active, state_r == ST_LUT, stat.active, "breathing level update while stopped")

endmodule

`default_nettype wire

### design/led_effect_generator_top.sv
// ----------------------------------------------------------------------------
// led_effect_generator_top
// single-pixel led effect engine: blink, breathing and color wheel
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream carries start, stop and tick commands with the current time
//   in ms. Each accepted item yields at most one transfer on out_* (pixel
//   color, brightness level, running flag). Registers are written through
//   cfg_we / cfg_idx / cfg_wdata, by the user only while the block is idle
//   (the block itself does not enforce this); any write to a defined
//   register also clears the cycle count.
//   Items are handled one at a time; in_tready is high only while the
//   sequencer is idle. A breathing tick reads the sine table, then multiplies,
//   before the result load; a tick without a result frees the input.
//   Start runs the 32-step shared divider for the phase step, after a first
//   period / limit division when a cycle limit is set; a zero effective
//   period skips the step division.
//   A finished result waits in the output register; the next item is still
//   accepted and its result is held back until out_tready frees the slot.
//   Synchronous reset on rst_n low: effect stopped, phases and counters
//   cleared, brightness level 255, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module led_effect_generator_top
  import ledfx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], now_ms[33:2], zero pad
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // red[7:0], green[15:8], blue[23:16],
                                                 // brightness[31:24], running[32], zero pad
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // sequencer
  ledfx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // effect datapath
  ledfx_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .ctl       (ctl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
